// ===== hw/rtl/bls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduled backlight slew package
// Shared widths, constants, payload structs, sequencer codes and helpers.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int LVL_W      = 7;
  localparam int TIME_W     = 32;
  localparam int FADE_W     = 8;
  localparam int H_W        = 14;   // 240 min * 60 s fits in 14 bits
  localparam int SPAN_W     = H_W + 1;
  localparam int ACC_W      = TIME_W + 2;
  localparam int OPND_W     = SPAN_W + LVL_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int CNT_W      = 3;

  localparam logic [LVL_W-1:0]  LEVEL_MAX  = 7'd100;
  localparam logic [LVL_W-1:0]  DAY_RST    = 7'd100;
  localparam logic [LVL_W-1:0]  NIGHT_RST  = 7'd40;
  localparam logic [LVL_W-1:0]  STEP_RST   = 7'd3;
  localparam logic [FADE_W-1:0] FADE_RST   = 8'd30;
  localparam logic [CNT_W-1:0]  ITER_LAST  = CNT_W'(LVL_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DAY   = 2'd0,
    REG_NIGHT = 2'd1,
    REG_FADE  = 2'd2,
    REG_STEP  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_s;
    logic [TIME_W-1:0] sunrise_s;
    logic [TIME_W-1:0] sunset_s;
    logic              times_valid;
  } bls_in_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             changed;
  } bls_out_t;

  typedef struct packed {
    logic [LVL_W-1:0] day;
    logic [LVL_W-1:0] night;
    logic [LVL_W-1:0] step;
    logic [H_W-1:0]   h;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIFF_RISE,
    OP_DIFF_SET,
    OP_ADD_H,
    OP_CHK_SPAN,
    OP_MC_A,
    OP_MC_B,
    OP_MUL_STEP,
    OP_ROUND,
    OP_DIV_STEP,
    OP_SLEW
  } op_t;

  typedef enum logic [1:0] {
    TGT_DAY,
    TGT_NIGHT,
    TGT_QUOT
  } tsel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF_R,
    ST_ADD_HR,
    ST_CHK_R,
    ST_DIFF_S,
    ST_ADD_HS,
    ST_CHK_S,
    ST_MC_A,
    ST_MUL_A,
    ST_MC_B,
    ST_MUL_B,
    ST_ROUND,
    ST_DIV,
    ST_SLEW
  } state_t;

  typedef struct packed {
    op_t   op;
    logic  tgt_we;
    tsel_t tsel;
    logic  sunset;
  } ctrl_t;

  typedef struct packed {
    logic vld;
    logic alu_neg;
    logic out_busy;
  } stat_t;

  // Half window in seconds: fade * 60 = fade * 64 - fade * 4
  function automatic logic [H_W-1:0] h_of(input logic [FADE_W-1:0] fade);
    return H_W'({fade, 6'b0}) - H_W'({fade, 2'b0});
  endfunction

  function automatic logic [LVL_W-1:0] sat_lvl(input logic [LVL_W-1:0] v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scheduled_backlight_slew_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduled backlight slew unit
// Picks a day, night or fade target from time and solar events and slews the
// driven backlight level toward it by a bounded step per tick.
//
// One request per tick on in_*: current time, sunrise, sunset, valid flag.
// Each request yields exactly one result on out_*: level and changed strobe.
// Configuration writes on cfg_* take effect at the clock edge of cfg_we.
// Path from accept to result: invalid times go from the sunrise difference
// straight to the slew, a tick before the sunrise window adds only the half
// window, other ticks check the windows, and a sunrise or sunset fade takes
// the long path, where one shared adder runs seven shift-add steps for each
// of the two products and seven restoring divide steps. in_ready is high only
// while the sequencer is idle, so a new request can be accepted in the cycle
// after a result is written. The result sits in an output register; a
// finished result may wait there while the next request is accepted, and the
// sequencer holds in its last step only if that register is still occupied.
// Reset restores default levels, step and window and sets the level to 100.
// ----------------------------------------------------------------------------
module scheduled_backlight_slew_unit
  import bls_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire bls_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output bls_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg;
  ctrl_t ctrl;
  stat_t stat;

  bls_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  bls_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/bls_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Backlight slew configuration registers
// Holds levels, step and the half fade window; saturates on write.
// ----------------------------------------------------------------------------
module bls_cfg
  import bls_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  logic [LVL_W-1:0]  day_r, night_r, step_r;
  logic [H_W-1:0]    h_r;
  logic [LVL_W-1:0]  lvl_in;
  logic [LVL_W-1:0]  step_sat;
  logic [FADE_W-1:0] fade_in;

  assign lvl_in   = sat_lvl(cfg_wdata[LVL_W-1:0]);
  assign step_sat = (lvl_in == '0) ? LVL_W'(1) : lvl_in;
  assign fade_in  = (cfg_wdata == '0) ? FADE_W'(1) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= DAY_RST;
      night_r <= NIGHT_RST;
      step_r  <= STEP_RST;
      h_r     <= h_of(FADE_RST);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DAY:   day_r   <= lvl_in;
        REG_NIGHT: night_r <= lvl_in;
        REG_FADE:  h_r     <= h_of(fade_in);
        REG_STEP:  step_r  <= step_sat;
      endcase
    end
  end

  assign cfg = '{day: day_r, night: night_r, step: step_r, h: h_r};

endmodule
`default_nettype wire

// ===== hw/rtl/bls_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Backlight slew shared adder
// One signed add/subtract with sign flag, reused by the sequencer's arithmetic steps.
// ----------------------------------------------------------------------------
module bls_alu
  import bls_pkg::*;
(
  input  wire logic [ACC_W-1:0] a,
  input  wire logic [ACC_W-1:0] b,
  input  wire logic             sub,
  output logic      [ACC_W-1:0] y,
  output logic                  neg
);

  assign y   = a + (b ^ {ACC_W{sub}}) + ACC_W'(sub);
  assign neg = y[ACC_W-1];

endmodule
`default_nettype wire

// ===== hw/rtl/bls_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Backlight slew datapath
// Time compares, shift-add fade product, restoring divide and level slew.
// ----------------------------------------------------------------------------
module bls_dp
  import bls_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire bls_in_t in_data,
  input  wire cfg_t    cfg,
  input  wire ctrl_t   ctrl,
  output stat_t        stat,
  output logic         out_valid,
  input  wire logic    out_ready,
  output bls_out_t     out_data
);

  logic [TIME_W-1:0] now_r, rise_r, set_r;
  logic              vld_r;
  logic [ACC_W-1:0]  acc_r;
  logic [SPAN_W-1:0] d_r;
  logic [OPND_W-1:0] opnd_r;
  logic [LVL_W-1:0]  mplr_r;
  logic [LVL_W-1:0]  target_r;
  logic [LVL_W-1:0]  level_r;
  logic              out_valid_r;
  bls_out_t          out_data_r;

  logic [SPAN_W-1:0] span;
  logic [ACC_W-1:0]  alu_a, alu_b, alu_y;
  logic              alu_sub, alu_neg;
  logic [LVL_W-1:0]  lvl_from, lvl_to;
  logic [LVL_W-1:0]  q_nxt;
  logic [LVL_W-1:0]  tgt_val;
  logic              slew_go;
  logic              up;
  logic [LVL_W-1:0]  diff, mv, lvl_new;

  assign span     = {cfg.h, 1'b0};
  assign lvl_from = ctrl.sunset ? cfg.day : cfg.night;
  assign lvl_to   = ctrl.sunset ? cfg.night : cfg.day;

  always_comb begin
    alu_a   = acc_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (ctrl.op)
      OP_DIFF_RISE: begin
        alu_a   = ACC_W'(now_r);
        alu_b   = ACC_W'(rise_r);
        alu_sub = 1'b1;
      end
      OP_DIFF_SET: begin
        alu_a   = ACC_W'(now_r);
        alu_b   = ACC_W'(set_r);
        alu_sub = 1'b1;
      end
      OP_ADD_H, OP_ROUND: begin
        alu_b = ACC_W'(cfg.h);
      end
      OP_CHK_SPAN: begin
        alu_b   = ACC_W'(span);
        alu_sub = 1'b1;
      end
      OP_MC_A: begin
        alu_a   = ACC_W'(span);
        alu_b   = ACC_W'(d_r);
        alu_sub = 1'b1;
      end
      OP_MUL_STEP: begin
        alu_b = mplr_r[0] ? ACC_W'(opnd_r) : '0;
      end
      OP_DIV_STEP: begin
        alu_b   = ACC_W'(opnd_r);
        alu_sub = 1'b1;
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  bls_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y),
    .neg (alu_neg)
  );

  assign q_nxt = {mplr_r[LVL_W-2:0], ~alu_neg};

  always_comb begin
    unique case (ctrl.tsel)
      TGT_DAY:   tgt_val = cfg.day;
      TGT_NIGHT: tgt_val = cfg.night;
      TGT_QUOT:  tgt_val = q_nxt;
      default:   tgt_val = cfg.day;
    endcase
  end

  // Move toward the target by at most one step
  assign slew_go = (ctrl.op == OP_SLEW);
  assign up      = target_r > level_r;
  assign diff    = up ? (target_r - level_r) : (level_r - target_r);
  assign mv      = (diff > cfg.step) ? cfg.step : diff;
  assign lvl_new = up ? (level_r + mv) : (level_r - mv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      level_r     <= DAY_RST;
    end else begin
      if (slew_go) begin
        out_valid_r <= 1'b1;
        level_r     <= lvl_new;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        now_r  <= in_data.now_s;
        rise_r <= in_data.sunrise_s;
        set_r  <= in_data.sunset_s;
        vld_r  <= in_data.times_valid;
      end
      OP_DIFF_RISE, OP_DIFF_SET, OP_ADD_H: begin
        acc_r <= alu_y;
      end
      OP_CHK_SPAN: begin
        d_r <= acc_r[SPAN_W-1:0];
      end
      OP_MC_A: begin
        opnd_r <= OPND_W'(alu_y[SPAN_W-1:0]);
        acc_r  <= '0;
        mplr_r <= lvl_from;
      end
      OP_MC_B: begin
        opnd_r <= OPND_W'(d_r);
        mplr_r <= lvl_to;
      end
      OP_MUL_STEP: begin
        acc_r  <= alu_y;
        opnd_r <= opnd_r << 1;
        mplr_r <= mplr_r >> 1;
      end
      OP_ROUND: begin
        acc_r  <= alu_y;
        opnd_r <= OPND_W'(span) << (LVL_W - 1);
        mplr_r <= '0;
      end
      OP_DIV_STEP: begin
        // keep the remainder only when the trial subtract did not go negative
        if (!alu_neg) begin
          acc_r <= alu_y;
        end
        opnd_r <= opnd_r >> 1;
        mplr_r <= q_nxt;
      end
      default: begin
      end
    endcase
    if (ctrl.tgt_we) begin
      target_r <= tgt_val;
    end
    if (slew_go) begin
      out_data_r.level   <= lvl_new;
      out_data_r.changed <= (lvl_new != level_r);
    end
  end

  assign stat = '{vld: vld_r, alu_neg: alu_neg, out_busy: out_valid_r & ~out_ready};

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/bls_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Backlight slew sequencer
// Steps the shared adder through compare, multiply, divide and slew.
// ----------------------------------------------------------------------------
module bls_ctrl
  import bls_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sunset_r, sunset_nxt;
  logic             last;

  assign last = (cnt_r == ITER_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      sunset_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      sunset_r <= sunset_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    sunset_nxt = sunset_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DIFF_R;
      ST_DIFF_R: state_nxt = stat.vld ? ST_ADD_HR : ST_SLEW;
      ST_ADD_HR: state_nxt = stat.alu_neg ? ST_SLEW : ST_CHK_R;
      ST_CHK_R: begin
        if (stat.alu_neg) begin
          sunset_nxt = 1'b0;
          state_nxt  = ST_MC_A;
        end else begin
          state_nxt = ST_DIFF_S;
        end
      end
      ST_DIFF_S: state_nxt = ST_ADD_HS;
      ST_ADD_HS: state_nxt = stat.alu_neg ? ST_SLEW : ST_CHK_S;
      ST_CHK_S: begin
        if (stat.alu_neg) begin
          sunset_nxt = 1'b1;
          state_nxt  = ST_MC_A;
        end else begin
          state_nxt = ST_SLEW;
        end
      end
      ST_MC_A: begin
        cnt_nxt   = '0;
        state_nxt = ST_MUL_A;
      end
      ST_MUL_A: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) state_nxt = ST_MC_B;
      end
      ST_MC_B: begin
        cnt_nxt   = '0;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) state_nxt = ST_SLEW;
      end
      ST_SLEW:   if (!stat.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    ctrl.op     = OP_NONE;
    ctrl.tgt_we = 1'b0;
    ctrl.tsel   = TGT_DAY;
    ctrl.sunset = sunset_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctrl.op = OP_LOAD;
      end
      ST_DIFF_R: begin
        ctrl.op = OP_DIFF_RISE;
        if (!stat.vld) begin
          ctrl.tgt_we = 1'b1;
          ctrl.tsel   = TGT_DAY;
        end
      end
      ST_ADD_HR: begin
        ctrl.op = OP_ADD_H;
        if (stat.alu_neg) begin
          ctrl.tgt_we = 1'b1;
          ctrl.tsel   = TGT_NIGHT;
        end
      end
      ST_CHK_R:  ctrl.op = OP_CHK_SPAN;
      ST_DIFF_S: ctrl.op = OP_DIFF_SET;
      ST_ADD_HS: begin
        ctrl.op = OP_ADD_H;
        if (stat.alu_neg) begin
          ctrl.tgt_we = 1'b1;
          ctrl.tsel   = TGT_DAY;
        end
      end
      ST_CHK_S: begin
        ctrl.op = OP_CHK_SPAN;
        if (!stat.alu_neg) begin
          ctrl.tgt_we = 1'b1;
          ctrl.tsel   = TGT_NIGHT;
        end
      end
      ST_MC_A:  ctrl.op = OP_MC_A;
      ST_MUL_A: ctrl.op = OP_MUL_STEP;
      ST_MC_B:  ctrl.op = OP_MC_B;
      ST_MUL_B: ctrl.op = OP_MUL_STEP;
      ST_ROUND: ctrl.op = OP_ROUND;
      ST_DIV: begin
        ctrl.op = OP_DIV_STEP;
        if (last) begin
          ctrl.tgt_we = 1'b1;
          ctrl.tsel   = TGT_QUOT;
        end
      end
      ST_SLEW:  if (!stat.out_busy) ctrl.op = OP_SLEW;
      default:  ctrl.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bls_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Backlight slew port checker
// Watches the top-level handshakes and result range over time.
// ----------------------------------------------------------------------------
module bls_checker
  import bls_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire bls_out_t out_data
);

  // busy after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after a request was accepted");

  // a fresh result only comes out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without the sequencer running");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.level <= LEVEL_MAX)
    else $error("result level above maximum");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

endmodule

bind scheduled_backlight_slew_unit bls_checker u_bls_checker (.*);
`default_nettype wire

// ===== verif/scheduled_backlight_slew_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduled backlight slew unit testbench
// Sends ticks of time, sunrise and sunset through the request channel under
// several level, window and step settings. Each accepted request is scored
// against a local model of the day/night/fade target and the bounded slew,
// and every result is checked in order on the result channel.
// ----------------------------------------------------------------------------
module scheduled_backlight_slew_unit_tb;
  import bls_pkg::*;

  localparam int  RANDOM_PER_PHASE = 244;
  localparam int  PHASES           = 8;
  localparam int  SETTLE_CYCLES    = 40;
  localparam int  CYCLE_LIMIT      = 1000000;
  localparam int  IDLE_PCT         = 16;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  bls_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  bls_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // model copy of the configuration and the driven level
  int day_pct   = 100;
  int night_pct = 40;
  int fade_min  = 30;
  int step_max  = 3;
  int level_now = 100;

  bls_in_t  pending_ticks[$];
  bls_out_t levels_due[$];
  bls_out_t want;
  int       mismatches = 0;
  int       cycles     = 0;
  bit       steady     = 1'b0;

  scheduled_backlight_slew_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint fade_pct(longint now_v, longint ev, longint h,
                                      longint start_pct, longint end_pct);
    longint span;
    longint d;
    span = 2 * h;
    d = now_v - ev + h;
    if (d < 0) d = 0;
    if (d > span) d = span;
    // half up: add half the span before the floor division
    return (start_pct * span + (end_pct - start_pct) * d + h) / span;
  endfunction

  function automatic bls_out_t predict_tick(bls_in_t t);
    longint   now_v;
    longint   rise_v;
    longint   set_v;
    longint   h;
    longint   target;
    longint   delta;
    int       prev;
    bls_out_t r;
    now_v  = longint'({32'd0, t.now_s});
    rise_v = longint'({32'd0, t.sunrise_s});
    set_v  = longint'({32'd0, t.sunset_s});
    h      = longint'(fade_min) * 60;
    if (!t.times_valid) target = day_pct;
    else if (now_v < rise_v - h) target = night_pct;
    else if (now_v < rise_v + h) target = fade_pct(now_v, rise_v, h, night_pct, day_pct);
    else if (now_v < set_v - h) target = day_pct;
    else if (now_v < set_v + h) target = fade_pct(now_v, set_v, h, day_pct, night_pct);
    else target = night_pct;
    if (target > 100) target = 100;
    delta = target - level_now;
    if (delta > step_max) delta = step_max;
    if (delta < -step_max) delta = -step_max;
    prev = level_now;
    level_now = int'(level_now + delta) & 8'h7f;
    r.level   = level_now[LVL_W-1:0];
    r.changed = (level_now != prev);
    return r;
  endfunction

  function automatic bls_in_t tick(logic [31:0] now_v, logic [31:0] rise_v,
                                   logic [31:0] set_v, logic ok);
    bls_in_t t;
    t.now_s       = now_v;
    t.sunrise_s   = rise_v;
    t.sunset_s    = set_v;
    t.times_valid = ok;
    return t;
  endfunction

  // mostly ticks around a sunrise or sunset window, the rest raw noise
  function automatic bls_in_t random_tick();
    bls_in_t     t;
    int          reach;
    int          off;
    logic [31:0] ev;
    t = tick($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 99) < 75) begin
      reach = 2 * fade_min * 60 + 120;
      case ($urandom_range(0, 3))
        0: t.sunrise_s = $urandom_range(0, 40000);
        1: t.sunrise_s = 32'hffff_ffff - $urandom_range(0, 40000);
        default: t.sunrise_s = $urandom;
      endcase
      t.sunset_s = t.sunrise_s + $urandom_range(0, 60000);
      ev = $urandom_range(0, 1) ? t.sunrise_s : t.sunset_s;
      off = int'($urandom_range(0, 2 * reach)) - reach;
      t.now_s = ev + off;
      t.times_valid = ($urandom_range(0, 9) != 0);
    end
    return t;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DAY:   day_pct   = (val[6:0] > 100) ? 100 : val[6:0];
      REG_NIGHT: night_pct = (val[6:0] > 100) ? 100 : val[6:0];
      REG_FADE:  fade_min  = (val == 0) ? 1 : val;
      REG_STEP:  step_max  = (val[6:0] == 0) ? 1 : ((val[6:0] > 100) ? 100 : val[6:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [7:0] d, logic [7:0] n, logic [7:0] f, logic [7:0] s);
    write_reg(REG_DAY, d);
    write_reg(REG_NIGHT, n);
    write_reg(REG_FADE, f);
    write_reg(REG_STEP, s);
  endtask

  // sample on the falling edge so driver and monitor updates have settled
  task automatic drain();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || levels_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_directed();
    logic [31:0] h;
    logic [31:0] rise_v;
    logic [31:0] set_v;
    h      = 32'(fade_min * 60);
    rise_v = 32'd100000;
    set_v  = 32'd150000;
    pending_ticks.push_back(tick(32'd0, 32'd0, 32'd0, 1'b0));
    pending_ticks.push_back(tick('1, '1, '1, 1'b0));
    pending_ticks.push_back(tick(32'd0, 32'd0, 32'd0, 1'b1));
    pending_ticks.push_back(tick('1, '1, '1, 1'b1));
    pending_ticks.push_back(tick('1, 32'd0, 32'd0, 1'b1));
    pending_ticks.push_back(tick(rise_v - h - 1, rise_v, set_v, 1'b1));
    pending_ticks.push_back(tick(rise_v - h, rise_v, set_v, 1'b1));
    // exact half step of the fade, rounds up
    pending_ticks.push_back(tick(rise_v - h + 30, rise_v, set_v, 1'b1));
    pending_ticks.push_back(tick(rise_v, rise_v, set_v, 1'b1));
    pending_ticks.push_back(tick(rise_v + h - 1, rise_v, set_v, 1'b1));
    pending_ticks.push_back(tick(rise_v + h, rise_v, set_v, 1'b1));
    pending_ticks.push_back(tick(set_v - h - 1, rise_v, set_v, 1'b1));
    pending_ticks.push_back(tick(set_v - h, rise_v, set_v, 1'b1));
    pending_ticks.push_back(tick(set_v + h - 1, rise_v, set_v, 1'b1));
    pending_ticks.push_back(tick(set_v + h, rise_v, set_v, 1'b1));
    // sunset ahead of sunrise
    pending_ticks.push_back(tick(set_v + h, set_v, rise_v, 1'b1));
    pending_ticks.push_back(tick(set_v, set_v, rise_v, 1'b1));
    pending_ticks.push_back(tick(rise_v, set_v, rise_v, 1'b1));
    // windows reaching past either end of the time range
    pending_ticks.push_back(tick(32'hffff_fff0, 32'hffff_ff00, '1, 1'b1));
    pending_ticks.push_back(tick(32'd5, 32'd10, 32'd20, 1'b1));
    pending_ticks.push_back(tick(rise_v, rise_v, set_v, 1'b0));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: ;
        1: write_all(8'd0, 8'd100, 8'd1, 8'd1);
        2: write_all(8'd100, 8'd0, 8'd240, 8'd100);
        3: write_all(8'hff, 8'd200, 8'd0, 8'd0);
        4: write_all(8'd50, 8'd10, 8'hff, 8'he5);
        default: write_all(8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 127)));
      endcase
      steady = (ph == 5);
      if (ph == 0) load_directed();
      repeat (RANDOM_PER_PHASE) pending_ticks.push_back(random_tick());
      drain();
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_ticks.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_data  <= pending_ticks.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and scoring
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      if (out_valid && out_ready) begin
        if (levels_due.size() == 0) begin
          $error("result with no request pending: level %0d changed %0b",
                 out_data.level, out_data.changed);
          mismatches++;
        end else begin
          want = levels_due.pop_front();
          if (out_data.level !== want.level) begin
            $error("level: expected %0d, actual %0d", want.level, out_data.level);
            mismatches++;
          end
          if (out_data.changed !== want.changed) begin
            $error("changed: expected %0b, actual %0b", want.changed, out_data.changed);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) levels_due.push_back(predict_tick(in_data));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hw/rtl/bls_pkg.sv
hw/rtl/bls_cfg.sv
hw/rtl/bls_alu.sv
hw/rtl/bls_dp.sv
hw/rtl/bls_ctrl.sv
hw/rtl/scheduled_backlight_slew_unit.sv
hw/rtl/bls_checker.sv
verif/scheduled_backlight_slew_unit_tb.sv
